>>> rtl/pctt_pkg.sv
// Shared constants, codes and controller/datapath handshake types of the tick tracker.
`default_nettype none

package pctt_pkg;

  localparam int MaxPropsDef  = 64;
  localparam int TickBitsDef  = 32;

  localparam int FuncW        = 2;
  localparam int TickW        = 32;
  localparam int PropW        = 6;
  localparam int NumPropsW    = 7;

  localparam logic [NumPropsW-1:0] NumPropsRst = 7'd64;

  typedef enum logic [FuncW-1:0] {
    FUNC_INIT  = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;
    logic mark_start;
    logic mark_finish;
    logic query_start;
    logic step;
    logic flush;
  } pctt_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic stream_done;
    logic need_push;
    logic out_free;
  } pctt_status_t;

endpackage

`default_nettype wire

>>> rtl/pctt_if.sv
// Valid/ready channel interfaces for input items, result words and the configuration write.
`default_nettype none

interface pctt_item_if import pctt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [TickW-1:0] tick;
  logic [PropW-1:0] prop_index;
  logic             has_prop;
  logic             list_end;

  modport source (output valid, func, tick, prop_index, has_prop, list_end, input ready);
  modport sink   (input valid, func, tick, prop_index, has_prop, list_end, output ready);
endinterface

interface pctt_res_if import pctt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PropW-1:0] changed_prop;
  logic             valid_res;
  logic             last;

  modport source (output valid, changed_prop, valid_res, last, input ready);
  modport sink   (input valid, changed_prop, valid_res, last, output ready);
endinterface

interface pctt_cfg_if import pctt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NumPropsW-1:0] num_props;

  modport source (output valid, num_props, input ready);
  modport sink   (input valid, num_props, output ready);
endinterface

`default_nettype wire

>>> rtl/pctt_datapath.sv
// Datapath: tick table, last-mark list memory, list tracking registers, query walk and result register.
`default_nettype none

module pctt_datapath import pctt_pkg::*; #(
  parameter int MaxProps = MaxPropsDef,
  parameter int TickBits = TickBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pctt_cmd_t            cmd_i,
  output pctt_status_t              status_o,
  input  wire logic [TickW-1:0]     item_tick_i,
  input  wire logic [PropW-1:0]     item_prop_i,
  input  wire logic                 item_has_prop_i,
  input  wire logic                 item_list_end_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [NumPropsW-1:0] cfg_data_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [PropW-1:0]          out_prop_o,
  output logic                      out_valid_res_o,
  output logic                      out_last_o
);

  localparam int AW = $clog2(MaxProps);
  localparam int CW = $clog2(MaxProps + 1);
  localparam logic [CW-1:0] MaxCnt = CW'(MaxProps);

  // Configuration and list bookkeeping
  logic [NumPropsW-1:0] num_props_q;
  logic [TickBits-1:0]  init_tick_q;
  logic [TickBits-1:0]  last_change_q;
  logic [TickBits-1:0]  same_since_q;
  logic [CW-1:0]        last_cnt_q;
  logic [CW-1:0]        old_cnt_q;
  logic [CW-1:0]        pos_q;
  logic                 same_q;
  logic [MaxProps-1:0]  entry_vld_q;

  // Latched mark item
  logic [TickBits-1:0]  mk_tick_q;
  logic [PropW-1:0]     mk_idx_q;
  logic                 mk_has_q;
  logic                 mk_end_q;

  // Query walk
  logic [TickBits-1:0]  qtick_q;
  logic                 cached_q;
  logic [CW-1:0]        len_q;
  logic [CW-1:0]        cnt_q;
  logic                 chk_valid_q;
  logic [AW-1:0]        chk_idx_q;
  logic                 pend_valid_q;
  logic [AW-1:0]        pend_idx_q;

  // Memories and their read registers
  logic [TickBits-1:0]  tab_mem [MaxProps];
  logic [AW-1:0]        list_mem [MaxProps];
  logic [TickBits-1:0]  tab_rd_q;
  logic                 tab_vld_rd_q;
  logic [AW-1:0]        list_rd_q;

  // Result register
  logic                 out_valid_q;
  logic [PropW-1:0]     out_prop_q;
  logic                 out_vres_q;
  logic                 out_last_q;

  logic [TickBits-1:0]  tick_in;
  logic [CW-1:0]        n_eff;
  logic [AW-1:0]        mk_addr;
  logic [AW-1:0]        pos_addr;
  logic [AW-1:0]        cnt_addr;
  logic                 mark_ok;
  logic                 list_hit;
  logic [CW-1:0]        pos_nx;
  logic                 same_nx;
  logic signed [TickBits:0] q_plus1;
  logic signed [TickBits:0] ss_ext;
  logic                 cached_in;
  logic                 recent;
  logic [CW-1:0]        len_in;
  logic [TickBits-1:0]  entry_tick;
  logic                 hit;
  logic [AW-1:0]        cand_idx;
  logic                 issue_ok;
  logic                 need_push;
  logic                 out_free;
  logic                 push_chk;
  logic                 tab_we;
  logic                 tab_re;
  logic                 list_re;
  logic [AW-1:0]        list_ra;

  assign tick_in  = item_tick_i[TickBits-1:0];
  assign n_eff    = (num_props_q > NumPropsW'(MaxProps)) ? MaxCnt : num_props_q[CW-1:0];
  assign mk_addr  = mk_idx_q[AW-1:0];
  assign pos_addr = pos_q[AW-1:0];
  assign cnt_addr = cnt_q[AW-1:0];

  // An element counts only when it is in range and the list still has room.
  assign mark_ok  = mk_has_q && (NumPropsW'(mk_idx_q) < NumPropsW'(n_eff)) && (pos_q < MaxCnt);
  assign list_hit = (pos_q < old_cnt_q) && (list_rd_q == mk_addr);
  assign pos_nx   = pos_q + CW'(mark_ok);
  assign same_nx  = same_q && !(mark_ok && !list_hit) && !(mk_end_q && (pos_nx != old_cnt_q));

  // The cached path is taken when tick + 1 >= same-since tick, worked out one bit wider.
  assign q_plus1   = $signed({tick_in[TickBits-1], tick_in}) + (TickBits + 1)'(1);
  assign ss_ext    = $signed({same_since_q[TickBits-1], same_since_q});
  assign cached_in = (q_plus1 >= ss_ext);
  assign recent    = ($signed(tick_in) < $signed(last_change_q));
  assign len_in    = cached_in ? (recent ? last_cnt_q : '0) : n_eff;

  // Entries not written since init read as the init tick.
  assign entry_tick = tab_vld_rd_q ? tab_rd_q : init_tick_q;
  assign hit        = cached_q || ($signed(entry_tick) > $signed(qtick_q));
  assign cand_idx   = cached_q ? list_rd_q : chk_idx_q;
  assign issue_ok   = (cnt_q < len_q);
  assign need_push  = chk_valid_q && hit && pend_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign push_chk   = cmd_i.step && need_push;

  assign tab_we  = cmd_i.mark_finish && mark_ok;
  assign tab_re  = cmd_i.step && issue_ok;
  assign list_re = (cmd_i.mark_start && (pos_q < MaxCnt)) || tab_re;
  assign list_ra = cmd_i.mark_start ? pos_addr : cnt_addr;

  assign status_o.stream_done = !issue_ok && !chk_valid_q;
  assign status_o.need_push   = need_push;
  assign status_o.out_free    = out_free;

  assign out_valid_o     = out_valid_q;
  assign out_prop_o      = out_prop_q;
  assign out_valid_res_o = out_vres_q;
  assign out_last_o      = out_last_q;

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[mk_addr] <= mk_tick_q;
      list_mem[pos_addr] <= mk_addr;
    end
    if (tab_re) begin
      tab_rd_q     <= tab_mem[cnt_addr];
      tab_vld_rd_q <= entry_vld_q[cnt_addr];
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_ra];
    end
    if (cmd_i.mark_start) begin
      mk_tick_q <= tick_in;
      mk_idx_q  <= item_prop_i;
      mk_has_q  <= item_has_prop_i;
      mk_end_q  <= item_list_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_props_q   <= NumPropsRst;
      init_tick_q   <= '0;
      last_change_q <= '0;
      same_since_q  <= '0;
      last_cnt_q    <= '0;
      old_cnt_q     <= '0;
      pos_q         <= '0;
      same_q        <= 1'b1;
      entry_vld_q   <= '0;
      qtick_q       <= '0;
      cached_q      <= 1'b0;
      len_q         <= '0;
      cnt_q         <= '0;
      chk_valid_q   <= 1'b0;
      chk_idx_q     <= '0;
      pend_valid_q  <= 1'b0;
      pend_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      out_prop_q    <= '0;
      out_vres_q    <= 1'b0;
      out_last_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_props_q <= cfg_data_i;
      end

      if (cmd_i.init) begin
        init_tick_q   <= tick_in;
        entry_vld_q   <= '0;
        last_change_q <= '0;
        same_since_q  <= '0;
        last_cnt_q    <= '0;
        old_cnt_q     <= '0;
        pos_q         <= '0;
        same_q        <= 1'b1;
      end

      // The first item of a list takes a snapshot of the previous list length.
      if (cmd_i.mark_start && (pos_q == '0)) begin
        old_cnt_q <= last_cnt_q;
        same_q    <= 1'b1;
      end

      if (cmd_i.mark_finish) begin
        if (mark_ok) begin
          entry_vld_q[mk_addr] <= 1'b1;
        end
        if (mk_end_q) begin
          if (!same_nx) begin
            same_since_q <= mk_tick_q;
          end
          last_change_q <= mk_tick_q;
          last_cnt_q    <= pos_nx;
          pos_q         <= '0;
          same_q        <= 1'b1;
        end else begin
          pos_q  <= pos_nx;
          same_q <= same_nx;
        end
      end

      if (cmd_i.query_start) begin
        qtick_q      <= tick_in;
        cached_q     <= cached_in;
        len_q        <= len_in;
        cnt_q        <= '0;
        chk_valid_q  <= 1'b0;
        pend_valid_q <= 1'b0;
      end

      // One entry is read per step while the previous one is checked.
      if (cmd_i.step) begin
        if (issue_ok) begin
          cnt_q       <= cnt_q + CW'(1);
          chk_valid_q <= 1'b1;
          chk_idx_q   <= cnt_addr;
        end else begin
          chk_valid_q <= 1'b0;
        end
        if (chk_valid_q && hit) begin
          pend_valid_q <= 1'b1;
          pend_idx_q   <= cand_idx;
        end
      end

      // A hit is held back one place so that the final word can carry last.
      if (push_chk) begin
        out_valid_q <= 1'b1;
        out_prop_q  <= PropW'(pend_idx_q);
        out_vres_q  <= 1'b1;
        out_last_q  <= 1'b0;
      end else if (cmd_i.flush) begin
        out_valid_q <= 1'b1;
        out_prop_q  <= pend_valid_q ? PropW'(pend_idx_q) : '0;
        out_vres_q  <= pend_valid_q;
        out_last_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/pctt_ctrl.sv
// Controller state machine that decodes input items and sequences marks and query walks.
`default_nettype none

module pctt_ctrl import pctt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [FuncW-1:0] func_i,
  input  wire logic             has_prop_i,
  input  wire logic             list_end_i,
  output logic                  in_ready_o,
  output pctt_cmd_t             cmd_o,
  input  wire pctt_status_t     status_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MARK,
    ST_QUERY,
    ST_FLUSH
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func_e'(func_i))
            FUNC_INIT: begin
              cmd_o.init = 1'b1;
            end
            FUNC_MARK: begin
              // An item with neither an index nor an end flag does nothing.
              if (has_prop_i || list_end_i) begin
                cmd_o.mark_start = 1'b1;
                state_d          = ST_MARK;
              end
            end
            FUNC_QUERY: begin
              cmd_o.query_start = 1'b1;
              state_d           = ST_QUERY;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        cmd_o.mark_finish = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_QUERY: begin
        if (status_i.stream_done) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.step = !status_i.need_push || status_i.out_free;
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/property_change_tick_tracker_top.sv
// A query walks L entries of the table memory, one entry per cycle while the output does not stall,
// where L is the tracked count for a table scan or the stored list length for a replay.
// One item is worked on at a time. Result words leave through a registered output stage.
// Reset (rst_ni, asynchronous, active low) clears all control state and per-entry valid bits,
// so the table reads as zero at once; no clearing pass is needed.
`default_nettype none

module property_change_tick_tracker_top import pctt_pkg::*; #(
  parameter int MaxProps = MaxPropsDef,
  parameter int TickBits = TickBitsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pctt_item_if.sink   item_i,
  pctt_cfg_if.sink    cfg_i,
  pctt_res_if.source  res_o
);

  pctt_cmd_t    cmd;
  pctt_status_t status;
  logic         in_ready;

  assign item_i.ready = in_ready;
  assign cfg_i.ready  = 1'b1;

  pctt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .func_i     (item_i.func),
    .has_prop_i (item_i.has_prop),
    .list_end_i (item_i.list_end),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  pctt_datapath #(
    .MaxProps (MaxProps),
    .TickBits (TickBits)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .item_tick_i     (item_i.tick),
    .item_prop_i     (item_i.prop_index),
    .item_has_prop_i (item_i.has_prop),
    .item_list_end_i (item_i.list_end),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.num_props),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .out_prop_o      (res_o.changed_prop),
    .out_valid_res_o (res_o.valid_res),
    .out_last_o      (res_o.last)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the property change tick tracker: random mark lists, inits and queries.
`default_nettype none

module tb_top import pctt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [PropW-1:0] prop;
    logic             hit;
    logic             last;
  } change_word_t;

  // Tracks the table, the last mark list and the same-since tick, and holds the words still owed.
  class tick_tracker_scoreboard;
    int unsigned          errors;
    logic [NumPropsW-1:0] num_props;
    longint               change_tick [MaxPropsDef];
    logic [PropW-1:0]     mark_list [MaxPropsDef];
    int unsigned          mark_count;
    int unsigned          mark_pos;
    int unsigned          old_count;
    longint               last_change;
    longint               same_since;
    bit                   still_same;
    change_word_t         expected_words[$];

    function new();
      errors = 0;
      num_props = NumPropsRst;
      foreach (change_tick[i]) begin
        change_tick[i] = 0;
        mark_list[i] = '0;
      end
      mark_count = 0;
      mark_pos = 0;
      old_count = 0;
      last_change = 0;
      same_since = 0;
      still_same = 1'b1;
    endfunction

    function int unsigned tracked();
      return (num_props > MaxPropsDef) ? MaxPropsDef : int'(num_props);
    endfunction

    function void push_word(logic [PropW-1:0] prop, logic hit, logic last);
      change_word_t w;
      w.prop = prop;
      w.hit = hit;
      w.last = last;
      expected_words.push_back(w);
    endfunction

    function void note_item(logic [FuncW-1:0] func, logic [TickW-1:0] tick_raw,
                            logic [PropW-1:0] idx, bit has_prop, bit list_end);
      longint      t;
      int unsigned n;
      int unsigned first;
      t = longint'($signed(tick_raw));
      n = tracked();
      first = expected_words.size();
      case (func)
        FUNC_INIT: begin
          foreach (change_tick[i]) change_tick[i] = t;
          mark_count = 0;
          last_change = 0;
          same_since = 0;
          mark_pos = 0;
          old_count = 0;
          still_same = 1'b1;
        end
        FUNC_MARK: begin
          if (has_prop || list_end) begin
            if (mark_pos == 0) begin
              old_count = mark_count;
              still_same = 1'b1;
            end
            if (has_prop && idx < n && mark_pos < MaxPropsDef) begin
              change_tick[idx] = t;
              if (!(mark_pos < old_count && mark_list[mark_pos] == idx)) still_same = 1'b0;
              mark_list[mark_pos] = idx;
              mark_pos++;
            end
            if (list_end) begin
              if (mark_pos != old_count) still_same = 1'b0;
              if (!still_same) same_since = t;
              last_change = t;
              mark_count = mark_pos;
              mark_pos = 0;
              still_same = 1'b1;
            end
          end
        end
        FUNC_QUERY: begin
          if (t + 1 >= same_since) begin
            if (t < last_change) begin
              for (int unsigned i = 0; i < mark_count; i++)
                push_word(mark_list[i], 1'b1, i + 1 == mark_count);
            end
          end else begin
            for (int unsigned i = 0; i < n; i++)
              if (change_tick[i] > t) push_word(PropW'(i), 1'b1, 1'b0);
            if (expected_words.size() > first)
              expected_words[expected_words.size() - 1].last = 1'b1;
          end
          // A query that finds nothing still answers with one empty word.
          if (expected_words.size() == first) push_word('0, 1'b0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [PropW-1:0] prop, logic hit, logic last);
      change_word_t w;
      if (expected_words.size() == 0) begin
        $error("unexpected result word: changed_prop %0d valid_res %0d last %0d", prop, hit, last);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (prop !== w.prop) begin
        $error("changed_prop: expected %0d, got %0d", w.prop, prop);
        errors++;
      end
      if (hit !== w.hit) begin
        $error("valid_res: expected %0d, got %0d", w.hit, hit);
        errors++;
      end
      if (last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;

  logic clk;
  logic rst_n;

  pctt_item_if item_bus ();
  pctt_res_if  res_bus ();
  pctt_cfg_if  cfg_bus ();

  property_change_tick_tracker_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .item_i (item_bus),
    .cfg_i  (cfg_bus),
    .res_o  (res_bus)
  );

  tick_tracker_scoreboard sb;
  logic [TickW-1:0]       now_tick;
  int                     items_done;
  int                     burst_left;
  bit                     steady_send;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver stalls follow a repeating 16-bit ready pattern, which is redrawn while the test runs.
  initial begin
    logic [15:0] stall_pattern;
    int unsigned cyc;
    stall_pattern = '1;
    cyc = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0)
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      res_bus.ready <= stall_pattern[cyc % 16];
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.check_word(res_bus.changed_prop, res_bus.valid_res, res_bus.last);
  end

  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Drives one word and returns at the edge where it is taken; valid stays high within a burst.
  task automatic send_word(input logic [FuncW-1:0] func, input logic [TickW-1:0] tick,
                           input logic [PropW-1:0] idx, input bit has_prop, input bit list_end);
    int gap;
    item_bus.valid      <= 1'b1;
    item_bus.func       <= func;
    item_bus.tick       <= tick;
    item_bus.prop_index <= idx;
    item_bus.has_prop   <= has_prop;
    item_bus.list_end   <= list_end;
    do @(posedge clk); while (!item_bus.ready);
    sb.note_item(func, tick, idx, has_prop, list_end);
    if (func == FUNC_INIT || func == FUNC_QUERY || (func == FUNC_MARK && (has_prop || list_end)))
      items_done++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_send ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain(input int settle);
    item_bus.valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_num_props(input logic [NumPropsW-1:0] value);
    // Marks leave no word behind, so allow the longest scan to finish before the write.
    drain(80);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.num_props <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    sb.num_props = value;
  endtask

  function automatic logic [PropW-1:0] pick_index();
    if ($urandom_range(0, 99) < 85) return PropW'($urandom_range(0, sb.tracked() - 1));
    return PropW'($urandom_range(0, 63));
  endfunction

  // Query ticks are aimed at the boundaries between the replay, the scan and the empty answer.
  function automatic logic [TickW-1:0] pick_query_tick();
    case ($urandom_range(0, 7))
      0: return now_tick + TickW'($urandom_range(0, 3));
      1: return TickW'(sb.last_change) - TickW'($urandom_range(1, 4));
      2: return TickW'(sb.same_since) - TickW'($urandom_range(2, 6));
      3: return TickW'(sb.same_since) - 1;
      4: return TickW'($urandom());
      5: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return now_tick - TickW'($urandom_range(0, 40));
    endcase
  endfunction

  // shape 0 draws a fresh list, 1 repeats the last one, 2 repeats it with one change.
  task automatic mark_list(input int len, input int shape, input bit plain);
    logic [PropW-1:0] elems[$];
    logic [TickW-1:0] t;
    bit               split_end;
    int               k;
    if (shape != 0) begin
      for (k = 0; k < int'(sb.mark_count); k++) elems.push_back(sb.mark_list[k]);
      if (shape == 2) begin
        if (elems.size() > 0 && $urandom_range(0, 1))
          elems[$urandom_range(0, elems.size() - 1)] = pick_index();
        else if (elems.size() > 1 && $urandom_range(0, 1))
          void'(elems.pop_back());
        else
          elems.push_back(pick_index());
      end
    end else begin
      for (k = 0; k < len; k++) elems.push_back(pick_index());
    end
    now_tick = now_tick + TickW'($urandom_range(1, 6));
    t = now_tick;
    if (elems.size() == 0) begin
      send_word(FUNC_MARK, t, PropW'($urandom_range(0, 63)), 1'b0, 1'b1);
      return;
    end
    split_end = !plain && $urandom_range(0, 9) == 0;
    for (k = 0; k < elems.size(); k++) begin
      if (!plain) begin
        if ($urandom_range(0, 19) == 0)
          send_word(FUNC_MARK, t, PropW'($urandom_range(0, 63)), 1'b0, 1'b0);
        if (k > 0 && $urandom_range(0, 14) == 0)
          send_word(FUNC_QUERY, pick_query_tick(), PropW'($urandom_range(0, 63)), 1'b0, 1'b0);
        if (k > 0 && $urandom_range(0, 39) == 0) begin
          // An init in the middle drops the half-marked list.
          send_word(FUNC_INIT, t, '0, 1'b0, 1'b0);
          return;
        end
      end
      send_word(FUNC_MARK, t + (($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0), elems[k], 1'b1,
                !split_end && k == elems.size() - 1);
    end
    if (split_end) send_word(FUNC_MARK, t, PropW'($urandom_range(0, 63)), 1'b0, 1'b1);
  endtask

  function automatic logic [NumPropsW-1:0] pick_num_props();
    case ($urandom_range(0, 5))
      0: return 7'd1;
      1: return 7'd2;
      2: return 7'd64;
      3: return NumPropsW'($urandom_range(65, 127));
      default: return NumPropsW'($urandom_range(3, 63));
    endcase
  endfunction

  initial begin
    int  pick;
    int  r;
    int  len;
    int  shape;
    bit  long_done;
    sb = new();
    items_done = 0;
    burst_left = 1;
    steady_send = 1'b0;
    long_done = 1'b0;
    now_tick = 32'd1000;
    item_bus.valid      <= 1'b0;
    item_bus.func       <= FUNC_INIT;
    item_bus.tick       <= '0;
    item_bus.prop_index <= '0;
    item_bus.has_prop   <= 1'b0;
    item_bus.list_end   <= 1'b0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.num_props   <= NumPropsRst;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: empty answers, full scans, replays, equal lists and a query inside a list.
    send_word(FUNC_QUERY, 32'd0, '0, 1'b0, 1'b0);
    send_word(FUNC_QUERY, 32'h8000_0000, '1, 1'b1, 1'b1);
    send_word(FUNC_INIT, 32'h8000_0000, '0, 1'b0, 1'b0);
    send_word(FUNC_QUERY, -32'sd5, '0, 1'b0, 1'b0);
    send_word(FUNC_MARK, 32'd100, 6'd63, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd100, 6'd0, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd100, 6'd5, 1'b1, 1'b1);
    send_word(FUNC_QUERY, 32'd99, '0, 1'b0, 1'b0);
    send_word(FUNC_QUERY, 32'd50, '0, 1'b0, 1'b0);
    send_word(FUNC_MARK, 32'd200, 6'd63, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd200, 6'd0, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd200, 6'd5, 1'b1, 1'b1);
    send_word(FUNC_QUERY, 32'd150, '0, 1'b0, 1'b0);
    send_word(FUNC_MARK, 32'd300, 6'd17, 1'b0, 1'b1);
    send_word(FUNC_QUERY, 32'd299, '0, 1'b0, 1'b0);
    send_word(FUNC_MARK, 32'd310, 6'd42, 1'b0, 1'b0);
    send_word(FuncUnused, 32'hFFFF_FFFF, '1, 1'b1, 1'b1);
    send_word(FUNC_MARK, 32'h7FFF_FFFF, 6'd7, 1'b1, 1'b0);
    send_word(FUNC_QUERY, 32'h7FFF_FFFF, '0, 1'b0, 1'b0);
    send_word(FUNC_QUERY, 32'd298, '0, 1'b0, 1'b0);
    send_word(FUNC_MARK, 32'h7FFF_FFFF, 6'd9, 1'b1, 1'b1);
    write_num_props(7'd1);
    send_word(FUNC_MARK, 32'd400, 6'd0, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd400, 6'd3, 1'b1, 1'b0);
    send_word(FUNC_MARK, 32'd400, 6'd0, 1'b1, 1'b1);
    send_word(FUNC_QUERY, 32'd399, '0, 1'b0, 1'b0);
    write_num_props(7'd127);

    while (items_done < 265) begin
      if (!long_done && items_done >= 150) begin
        // One list longer than the table to hit the position limit, then replay it.
        mark_list(80, 0, 1'b1);
        send_word(FUNC_QUERY, TickW'(sb.last_change) - 1, '0, 1'b0, 1'b0);
        long_done = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) steady_send = !steady_send;
      if ($urandom_range(0, 49) == 0) now_tick = TickW'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 45 || pick >= 97) begin
        r = $urandom_range(0, 19);
        len = (r == 0) ? 0 : (r < 14) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        r = $urandom_range(0, 9);
        shape = (r < 5) ? 0 : (r < 8) ? 1 : 2;
        mark_list(len, shape, 1'b0);
        if (pick >= 97) send_word(FUNC_QUERY, TickW'(sb.last_change) - 1, '0, 1'b0, 1'b0);
      end else if (pick < 78) begin
        send_word(FUNC_QUERY, pick_query_tick(), PropW'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick < 83) begin
        now_tick = now_tick + TickW'($urandom_range(1, 6));
        send_word(FUNC_INIT,
                  ($urandom_range(0, 3) == 0) ? TickW'($urandom())
                                              : now_tick - TickW'($urandom_range(0, 50)),
                  PropW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: send_word(FuncUnused, TickW'($urandom()), PropW'($urandom_range(0, 63)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          1: send_word(FUNC_MARK, TickW'($urandom()), PropW'($urandom_range(0, 63)), 1'b0, 1'b0);
          default: begin
            if (sb.tracked() < MaxPropsDef)
              send_word(FUNC_MARK, now_tick, PropW'($urandom_range(sb.tracked(), 63)), 1'b1, 1'b0);
            else
              send_word(FUNC_MARK, now_tick, PropW'($urandom_range(0, 63)), 1'b0, 1'b0);
          end
        endcase
      end else if (pick < 94) begin
        drain($urandom_range(1, 20));
      end else begin
        write_num_props(pick_num_props());
      end
    end

    drain(100);
    if (sb.errors == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire

>>> property_change_tick_tracker_top.f
rtl/pctt_pkg.sv
rtl/pctt_if.sv
rtl/pctt_datapath.sv
rtl/pctt_ctrl.sv
rtl/property_change_tick_tracker_top.sv
tb/tb_top.sv
